### hdl/bchd_pkg.sv
package bchd_pkg;

    // default sizes
    localparam int DEF_NUM_BUTTONS  = 4;
    localparam int DEF_NUM_TRIGGERS = 8;

    // fixed field widths
    localparam int TICK_W    = 16;
    localparam int CLICK_W   = 4;
    localparam int BTN_W     = 2;
    localparam int ENTRY_W   = 8;
    localparam int FIRED_W   = 8;
    localparam int TABLE_W   = 64;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int IN_TDW    = 8;
    localparam int OUT_TDW   = 16;

    localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_IDLE_TICKS     = 3'd0;
    localparam logic [2:0] REG_HOLD_TICKS     = 3'd1;
    localparam logic [2:0] REG_ACTIVE_LEVELS  = 3'd2;
    localparam logic [2:0] REG_BUTTONS_IN_USE = 3'd3;
    localparam logic [2:0] REG_TRIGGER_TABLE  = 3'd4;

    // trigger entry bit positions
    localparam int ENT_VALID_BIT = 7;
    localparam int ENT_HOLD_BIT  = 6;
    localparam int ENT_BTN_LSB   = 4;

    // gesture phase, stored per button and reported with each result
    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_PREP_PRESS   = 3'd1,
        PH_PRESSING     = 3'd2,
        PH_PREP_RELEASE = 3'd3,
        PH_RELEASE      = 3'd4,
        PH_HOLDING      = 3'd5,
        PH_PREP_IDLE    = 3'd6
    } phase_t;

    // one per-button state word; all zero is the reset value
    typedef struct packed {
        phase_t              phase;
        logic [TICK_W-1:0]   ticks;
        logic [CLICK_W-1:0]  clicks;
        logic                hold;
    } bchd_state_t;

    // static configuration seen by the gesture logic
    typedef struct packed {
        logic [TICK_W-1:0]   idle_ticks;
        logic [TICK_W-1:0]   hold_ticks;
        logic [TABLE_W-1:0]  trigger_table;
    } bchd_cfg_t;

endpackage

### hdl/bchd_state_ram.sv
module bchd_state_ram #(
    parameter int DEPTH = bchd_pkg::DEF_NUM_BUTTONS,
    parameter int AW    = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  bchd_pkg::bchd_state_t  wr_data,
    output bchd_pkg::bchd_state_t  rd_data
);
    import bchd_pkg::*;

    bchd_state_t       mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    bchd_state_t       rdata_reg;
    logic              rvalid_reg;
    logic [AW-1:0]     raddr_reg;
    bchd_state_t       fwd_data_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic              fwd_valid_reg;

    // storage array, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // entry written flags, an unwritten entry reads as the reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
            raddr_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= written_reg[rd_addr];
                raddr_reg  <= rd_addr;
            end
        end
    end

    // last write kept for forwarding to a read of the same entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg  <= '0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
            fwd_addr_reg  <= wr_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // read data with forwarding of the newest write
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == raddr_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (rvalid_reg)
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

### hdl/bchd_gesture.sv
module bchd_gesture #(
    parameter int NUM_TRIGGERS = bchd_pkg::DEF_NUM_TRIGGERS
) (
    input  bchd_pkg::bchd_state_t              cur,
    input  logic                               pressed,
    input  logic [bchd_pkg::BTN_W-1:0]         btn,
    input  bchd_pkg::bchd_cfg_t                cfg,
    input  logic [NUM_TRIGGERS-1:0]            served,
    output bchd_pkg::bchd_state_t              nxt,
    output logic [NUM_TRIGGERS-1:0]            served_next,
    output logic [NUM_TRIGGERS-1:0]            fired
);
    import bchd_pkg::*;

    logic [ENTRY_W-1:0] entry [NUM_TRIGGERS];

    // split the trigger table into entries
    always_comb
    begin
        for (int e = 0; e < NUM_TRIGGERS; e++)
        begin
            entry[e] = cfg.trigger_table[ENTRY_W*e +: ENTRY_W];
        end
    end

    // phase machine step and trigger matching
    always_comb
    begin
        logic [NUM_TRIGGERS-1:0] srv;
        nxt = cur;
        srv = served;
        fired = '0;

        unique case (cur.phase)
            PH_IDLE:
            begin
                nxt.clicks = '0;
                nxt.hold   = 1'b0;
                if (pressed)
                begin
                    nxt.ticks = '0;
                    nxt.phase = PH_PREP_PRESS;
                    for (int e = 0; e < NUM_TRIGGERS; e++)
                    begin
                        if (entry[e][ENT_BTN_LSB +: BTN_W] == btn)
                        begin
                            srv[e] = 1'b0;
                        end
                    end
                end
            end
            PH_PREP_PRESS:
            begin
                nxt.phase = PH_PRESSING;
                nxt.ticks = '0;
            end
            PH_PRESSING:
            begin
                if (!pressed)
                begin
                    nxt.phase = PH_PREP_RELEASE;
                end
                else if (cur.ticks >= cfg.hold_ticks)
                begin
                    nxt.phase = PH_HOLDING;
                    nxt.ticks = '0;
                end
                else
                begin
                    nxt.ticks = cur.ticks + TICK_W'(1);
                end
            end
            PH_PREP_RELEASE:
            begin
                nxt.ticks = '0;
                if (cur.clicks != CLICK_MAX)
                begin
                    nxt.clicks = cur.clicks + CLICK_W'(1);
                end
                nxt.phase = PH_RELEASE;
            end
            PH_RELEASE:
            begin
                if (pressed)
                begin
                    nxt.phase = PH_PREP_PRESS;
                end
                else if (cur.ticks >= cfg.idle_ticks)
                begin
                    nxt.phase = PH_PREP_IDLE;
                end
                else
                begin
                    nxt.ticks = cur.ticks + TICK_W'(1);
                end
            end
            PH_HOLDING:
            begin
                nxt.hold = 1'b1;
                if (!pressed)
                begin
                    nxt.ticks = '0;
                    nxt.phase = PH_RELEASE;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
                nxt.ticks = '0;
            end
        endcase

        // fire matching unserved entries in holding or pre-idle
        if (nxt.phase == PH_PREP_IDLE || nxt.phase == PH_HOLDING)
        begin
            for (int e = 0; e < NUM_TRIGGERS; e++)
            begin
                if (entry[e][ENT_VALID_BIT] &&
                    entry[e][ENT_BTN_LSB +: BTN_W] == btn &&
                    entry[e][CLICK_W-1:0] == nxt.clicks &&
                    entry[e][ENT_HOLD_BIT] == nxt.hold &&
                    !srv[e])
                begin
                    srv[e]   = 1'b1;
                    fired[e] = 1'b1;
                end
            end
        end
        served_next = srv;
    end

endmodule

### hdl/button_click_hold_detector.sv
// Multi-click and long-press detector for up to NUM_BUTTONS buttons sharing
// one table of NUM_TRIGGERS triggers. Each slave transaction is one tick of
// one button; each brings exactly one master transaction with the button's
// click count, hold flag, phase and the triggers that fired. Per-button state
// lives in a small synchronous memory read at acceptance and written back when
// the tick advances, with the last write forwarded, so a tick is accepted every
// cycle while the output is not stalled; its result passes through the tick stage
// register and the result register to the master side.
// The result register lets the next tick enter while a result waits.
// Configuration goes through the register port: idle_ticks at 0x00,
// hold_ticks at 0x08, active_levels at 0x10, buttons_in_use at 0x18 and the
// trigger table (entry e in bits 8e+7..8e: valid, hold, button, clicks) at
// 0x20; write it only while no tick is in flight.
module button_click_hold_detector #(
    parameter int NUM_BUTTONS  = bchd_pkg::DEF_NUM_BUTTONS,
    parameter int NUM_TRIGGERS = bchd_pkg::DEF_NUM_TRIGGERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bchd_pkg::APB_AW-1:0]   paddr,
    input  logic [bchd_pkg::APB_DW-1:0]   pwdata,
    output logic [bchd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // tick stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bchd_pkg::IN_TDW-1:0]   s_tdata,  // button_index[1:0], pin_level[2]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bchd_pkg::OUT_TDW-1:0]  m_tdata   // clicks[3:0], hold_flag[4],
                                                    // phase[7:5], fired_mask[15:8]
);
    import bchd_pkg::*;

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [2:0] BTN_CNT = 3'(NUM_BUTTONS);

    // configuration registers
    logic [TICK_W-1:0]        idle_ticks_reg;
    logic [TICK_W-1:0]        hold_ticks_reg;
    logic [3:0]               active_levels_reg;
    logic [2:0]               buttons_in_use_reg;
    logic [TABLE_W-1:0]       trigger_table_reg;

    // pipeline
    logic                     s1_valid_reg;
    logic [BTN_W-1:0]         s1_btn_reg;
    logic                     s1_level_reg;
    logic                     m_valid_reg;
    logic [OUT_TDW-1:0]       m_tdata_reg;
    logic [NUM_TRIGGERS-1:0]  served_reg;
    logic [NUM_TRIGGERS-1:0]  served_next;

    logic                     accept;
    logic                     advance;
    logic                     cfg_write;
    logic [2:0]               reg_idx;
    logic [BTN_W-1:0]         in_btn;
    logic                     s1_in_range;
    logic                     s1_in_use;
    logic                     s1_pressed;
    bchd_state_t              cur_state;
    bchd_state_t              nxt_state;
    bchd_cfg_t                cfg;
    logic [NUM_TRIGGERS-1:0]  fired;
    logic [OUT_TDW-1:0]       result;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg     <= '0;
            hold_ticks_reg     <= '0;
            active_levels_reg  <= '0;
            buttons_in_use_reg <= '0;
            trigger_table_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_IDLE_TICKS:     idle_ticks_reg     <= pwdata[TICK_W-1:0];
                REG_HOLD_TICKS:     hold_ticks_reg     <= pwdata[TICK_W-1:0];
                REG_ACTIVE_LEVELS:  active_levels_reg  <= pwdata[3:0];
                REG_BUTTONS_IN_USE: buttons_in_use_reg <= pwdata[2:0];
                REG_TRIGGER_TABLE:  trigger_table_reg  <= pwdata;
                default:            ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_IDLE_TICKS:     prdata = APB_DW'(idle_ticks_reg);
            REG_HOLD_TICKS:     prdata = APB_DW'(hold_ticks_reg);
            REG_ACTIVE_LEVELS:  prdata = APB_DW'(active_levels_reg);
            REG_BUTTONS_IN_USE: prdata = APB_DW'(buttons_in_use_reg);
            REG_TRIGGER_TABLE:  prdata = trigger_table_reg;
            default:            prdata = '0;
        endcase
    end

    // stream handshake
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign in_btn   = s_tdata[BTN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // tick payload held while its state is read, result word registered on advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_btn_reg   <= in_btn;
            s1_level_reg <= s_tdata[BTN_W];
        end
        if (advance)
        begin
            m_tdata_reg <= result;
        end
    end

    // per-button state memory
    bchd_state_ram #(
        .DEPTH (NUM_BUTTONS),
        .AW    (AW)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_btn[AW-1:0]),
        .wr_en   (advance && s1_in_use),
        .wr_addr (s1_btn_reg[AW-1:0]),
        .wr_data (nxt_state),
        .rd_data (cur_state)
    );

    // button decode for the tick in flight
    assign s1_in_range = {1'b0, s1_btn_reg} < BTN_CNT;
    assign s1_in_use   = s1_in_range && ({1'b0, s1_btn_reg} < buttons_in_use_reg);
    assign s1_pressed  = s1_level_reg == active_levels_reg[s1_btn_reg];

    assign cfg.idle_ticks    = idle_ticks_reg;
    assign cfg.hold_ticks    = hold_ticks_reg;
    assign cfg.trigger_table = trigger_table_reg;

    bchd_gesture #(
        .NUM_TRIGGERS (NUM_TRIGGERS)
    ) u_gesture (
        .cur         (cur_state),
        .pressed     (s1_pressed),
        .btn         (s1_btn_reg),
        .cfg         (cfg),
        .served      (served_reg),
        .nxt         (nxt_state),
        .served_next (served_next),
        .fired       (fired)
    );

    // served marks of the trigger table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= '0;
        end
        else if (advance && s1_in_use)
        begin
            served_reg <= served_next;
        end
    end

    // result word
    always_comb
    begin
        if (s1_in_use)
        begin
            result = {FIRED_W'(fired), nxt_state.phase, nxt_state.hold, nxt_state.clicks};
        end
        else if (s1_in_range)
        begin
            result = {FIRED_W'(0), cur_state.phase, cur_state.hold, cur_state.clicks};
        end
        else
        begin
            result = '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
